>>> rtl/pcg32b_pkg.sv
`timescale 1ns / 1ps
package pcg32b_pkg;

	localparam int WORD_W     = 32;
	localparam int STATE_W    = 64;
	localparam int STREAM_W   = 63;
	localparam int FRAC_W     = 24;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int CNT_W      = $clog2(WORD_W);

	localparam logic [STATE_W-1:0] LCG_MULT    = 64'h5851F42D4C957F2D;
	localparam logic [STATE_W-1:0] RESET_STATE = 64'h5851F42D4C957F2E;
	localparam logic [STATE_W-1:0] RESET_INC   = 64'h0000000000000001;

	typedef enum logic [1:0] {
		OP_RESEED   = 2'd0,
		OP_RAW      = 2'd1,
		OP_BOUNDED  = 2'd2,
		OP_INTERVAL = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEED   = 1'b0,
		REG_STREAM = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_D0,
		ST_D1,
		ST_D2,
		ST_D3,
		ST_SEED,
		ST_LEM0,
		ST_LEM1,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rem_status_t;

	function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] s);
		logic [STATE_W-1:0]  x;
		logic [WORD_W-1:0]   xs;
		logic [4:0]          rot;
		logic [2*WORD_W-1:0] d;
		x   = (s >> 18) ^ s;
		xs  = x[58:27];
		rot = s[63:59];
		d   = {xs, xs} >> rot;
		return d[WORD_W-1:0];
	endfunction

endpackage

>>> rtl/pcg32b_if.sv
`timescale 1ns / 1ps
interface pcg32b_in_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          operation;
	logic [pcg32b_pkg::WORD_W-1:0]        bound;
	logic signed [pcg32b_pkg::WORD_W-1:0] range_low;
	logic signed [pcg32b_pkg::WORD_W-1:0] range_high;

	modport source (output valid, operation, bound, range_low, range_high, input ready);
	modport sink (input valid, operation, bound, range_low, range_high, output ready);
endinterface

interface pcg32b_out_if;
	logic                                valid;
	logic                                ready;
	logic [pcg32b_pkg::WORD_W-1:0]        word;
	logic signed [pcg32b_pkg::WORD_W-1:0] signed_result;
	logic [pcg32b_pkg::FRAC_W-1:0]        unit_fraction;
	logic                                coin;

	modport source (output valid, word, signed_result, unit_fraction, coin, input ready);
	modport sink (input valid, word, signed_result, unit_fraction, coin, output ready);
endinterface

>>> rtl/pcg32b_rem.sv
`timescale 1ns / 1ps
module pcg32b_rem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pcg32b_pkg::WORD_W-1:0] divisor,
	output pcg32b_pkg::rem_status_t       status,
	output logic [pcg32b_pkg::WORD_W-1:0] remainder
);
	import pcg32b_pkg::*;

	logic [WORD_W-1:0] dvd_q;
	logic [WORD_W-1:0] dsr_q;
	logic [WORD_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WORD_W:0]   trial;
	logic [WORD_W:0]   diff;
	logic [WORD_W-1:0] rem_next;

	// restoring step on the remainder of (2^32 - n) by n
	always_comb begin
		trial    = {rem_q, dvd_q[WORD_W-1]};
		diff     = trial - {1'b0, dsr_q};
		rem_next = (trial >= {1'b0, dsr_q}) ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= '0 - divisor;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign remainder   = rem_q;

endmodule

>>> rtl/pcg32_bounded_random_generator_top.sv
`timescale 1ns / 1ps
// PCG32 generator with unbiased bounded and signed interval draws.
// cmd channel: operation (reseed, raw, bounded, interval) with bound and range ends.
// res channel: word, signed_result, unit_fraction and coin, one transfer per command.
// cfg port: cfg_wr_en writes seed (index 0) or stream (index 1); takes effect at reseed.
// One item at a time: cmd.ready is high only while the sequencer is idle.
// Each draw runs the 64-bit LCG step through one shared 32x32 multiplier in states
// D0 to D3 (three partial products plus the accumulate).
// Bounded and interval draws redraw on rejection; the rejection threshold is
// computed at most once per command by a bit-serial remainder unit. A zero
// bound, an interval with low >= high and the full interval skip the LCG step
// and go straight to the result.
// A result waits in the output register while the receiver stalls; the next command
// is still taken and runs until its own result needs the register.
// Reset loads the state left by a reseed with seed 0 and stream 0.
module pcg32_bounded_random_generator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	pcg32b_in_if.sink                         cmd,
	pcg32b_out_if.source                      res,
	input  logic                              cfg_wr_en,
	input  logic [pcg32b_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcg32b_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pcg32b_pkg::*;

	state_t              state_q, state_d;
	op_t                 op_q;
	logic [STATE_W-1:0]  lcg_state_q;
	logic [STATE_W-1:0]  inc_q;
	logic [STATE_W-1:0]  seed_q;
	logic [STREAM_W-1:0] stream_q;
	logic [STATE_W-1:0]  acc_q;
	logic [STATE_W-1:0]  prod_q;
	logic [STATE_W-1:0]  prod;
	logic [WORD_W-1:0]   mul_a, mul_b;
	logic [WORD_W-1:0]   xs_q;
	logic [WORD_W-1:0]   n_q;
	logic [WORD_W-1:0]   lo_q;
	logic [WORD_W-1:0]   thr_q;
	logic [WORD_W-1:0]   res_q;
	logic                thr_ok_q;
	logic                pass_q;
	logic                out_valid_q;
	logic [WORD_W-1:0]   word_q;
	logic [WORD_W-1:0]   sres_q;
	logic [FRAC_W-1:0]   frac_q;
	logic                coin_q;
	logic [WORD_W-1:0]   in_len;
	logic                in_skip;
	logic                low_rej;
	logic                out_load;
	logic                rem_start;
	logic                ready;
	rem_status_t         rem_st;
	logic [WORD_W-1:0]   rem_val;

	pcg32b_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.divisor   (n_q),
		.status    (rem_st),
		.remainder (rem_val)
	);

	always_comb begin
		in_len  = $unsigned(cmd.range_high) - $unsigned(cmd.range_low) + 32'd1;
		in_skip = ((op_t'(cmd.operation) == OP_BOUNDED) && (cmd.bound == '0)) ||
			((op_t'(cmd.operation) == OP_INTERVAL) &&
			((cmd.range_low >= cmd.range_high) || (in_len == '0)));
		low_rej = thr_ok_q ? (prod_q[WORD_W-1:0] < thr_q) : (prod_q[WORD_W-1:0] < n_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) state_d = in_skip ? ST_FIN : ST_D0;
			end
			ST_D0: state_d = ST_D1;
			ST_D1: state_d = ST_D2;
			ST_D2: state_d = ST_D3;
			ST_D3: begin
				case (op_q)
					OP_RESEED: state_d = pass_q ? ST_FIN : ST_SEED;
					OP_RAW:    state_d = ST_FIN;
					default:   state_d = ST_LEM0;
				endcase
			end
			ST_SEED: state_d = ST_D0;
			ST_LEM0: state_d = ST_LEM1;
			ST_LEM1: begin
				if (!low_rej) state_d = ST_FIN;
				else          state_d = thr_ok_q ? ST_D0 : ST_DIV;
			end
			ST_DIV: begin
				if (rem_st.done) state_d = ST_LEM1;
			end
			ST_FIN: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ready     = (state_q == ST_IDLE);
		out_load  = (state_q == ST_FIN) && (!out_valid_q || res.ready);
		rem_start = (state_q == ST_LEM1) && low_rej && !thr_ok_q;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_D0: begin
				mul_a = lcg_state_q[WORD_W-1:0];
				mul_b = LCG_MULT[WORD_W-1:0];
			end
			ST_D1: begin
				mul_a = lcg_state_q[STATE_W-1:WORD_W];
				mul_b = LCG_MULT[WORD_W-1:0];
			end
			ST_D2: begin
				mul_a = lcg_state_q[WORD_W-1:0];
				mul_b = LCG_MULT[STATE_W-1:WORD_W];
			end
			ST_LEM0: begin
				mul_a = xs_q;
				mul_b = n_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = 64'(mul_a) * 64'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			lcg_state_q <= RESET_STATE;
			inc_q       <= RESET_INC;
			seed_q      <= '0;
			stream_q    <= '0;
			thr_ok_q    <= 1'b0;
			pass_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)               out_valid_q <= 1'b1;
			else if (res.ready)         out_valid_q <= 1'b0;
			if (cfg_wr_en) begin
				case (reg_idx_t'(cfg_index))
					REG_SEED:   seed_q   <= cfg_data;
					REG_STREAM: stream_q <= cfg_data[STREAM_W-1:0];
					default:    seed_q   <= seed_q;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					thr_ok_q <= 1'b0;
					pass_q   <= 1'b0;
					if (cmd.valid && (op_t'(cmd.operation) == OP_RESEED)) begin
						inc_q       <= {stream_q, 1'b1};
						lcg_state_q <= '0;
					end
				end
				ST_D3: begin
					lcg_state_q <= {acc_q[STATE_W-1:WORD_W] + prod_q[WORD_W-1:0],
						acc_q[WORD_W-1:0]};
				end
				ST_SEED: begin
					lcg_state_q <= lcg_state_q + seed_q;
					pass_q      <= 1'b1;
				end
				ST_DIV: begin
					if (rem_st.done) thr_ok_q <= 1'b1;
				end
				default: thr_ok_q <= thr_ok_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q  <= op_t'(cmd.operation);
				lo_q  <= $unsigned(cmd.range_low);
				res_q <= '0;
				n_q   <= (op_t'(cmd.operation) == OP_INTERVAL) ? in_len : cmd.bound;
			end
			ST_D0: begin
				xs_q   <= xsh_rr(lcg_state_q);
				prod_q <= prod;
			end
			ST_D1: begin
				acc_q  <= inc_q + prod_q;
				prod_q <= prod;
			end
			ST_D2: begin
				acc_q[STATE_W-1:WORD_W] <= acc_q[STATE_W-1:WORD_W] + prod_q[WORD_W-1:0];
				prod_q                  <= prod;
			end
			ST_LEM0: prod_q <= prod;
			ST_LEM1: begin
				if (!low_rej) res_q <= prod_q[STATE_W-1:WORD_W];
			end
			ST_DIV: begin
				if (rem_st.done) thr_q <= rem_val;
			end
			default: res_q <= res_q;
		endcase
		if (out_load) begin
			case (op_q)
				OP_RAW: begin
					word_q <= xs_q;
					sres_q <= '0;
					frac_q <= xs_q[WORD_W-1:WORD_W-FRAC_W];
					coin_q <= xs_q[WORD_W-1];
				end
				OP_BOUNDED: begin
					word_q <= res_q;
					sres_q <= '0;
					frac_q <= '0;
					coin_q <= 1'b0;
				end
				OP_INTERVAL: begin
					word_q <= '0;
					sres_q <= lo_q + res_q;
					frac_q <= '0;
					coin_q <= 1'b0;
				end
				default: begin
					word_q <= '0;
					sres_q <= '0;
					frac_q <= '0;
					coin_q <= 1'b0;
				end
			endcase
		end
	end

	assign cmd.ready         = ready;
	assign res.valid         = out_valid_q;
	assign res.word          = word_q;
	assign res.signed_result = $signed(sres_q);
	assign res.unit_fraction = frac_q;
	assign res.coin          = coin_q;

	a_inc_odd: assert property (@(posedge clk) disable iff (!arst_n) inc_q[0])
		else $error("LCG increment lost its low bit");

	a_idle_rem: assert property (@(posedge clk) disable iff (!arst_n)
		ready |-> !rem_st.busy)
		else $error("remainder unit busy while idle");

	a_thr_below_n: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LEM1) && thr_ok_q) |-> (thr_q < n_q))
		else $error("rejection threshold not below bound");

	a_raw_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && ready && (op_t'(cmd.operation) == OP_RAW)) |=> (state_q == ST_D0))
		else $error("raw draw did not start the LCG step");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import pcg32b_pkg::*;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [WORD_W-1:0] sres;
		logic [FRAC_W-1:0] frac;
		logic              coin;
	} draw_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pcg32b_in_if  cmd_ch ();
	pcg32b_out_if res_ch ();

	pcg32_bounded_random_generator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [STATE_W-1:0]  lcg_st;
	logic [STATE_W-1:0]  lcg_inc;
	logic [STATE_W-1:0]  seed_reg;
	logic [STREAM_W-1:0] stream_reg;
	draw_result_t        pending_draws[$];
	int                  mismatches;
	bit                  idle_on;
	int                  hold_left;
	int                  rx_wait;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [WORD_W-1:0] lcg_advance();
		logic [STATE_W-1:0] prev;
		logic [WORD_W-1:0]  xs;
		logic [4:0]         rot;
		prev   = lcg_st;
		lcg_st = prev * LCG_MULT + lcg_inc;
		xs     = WORD_W'(((prev >> 18) ^ prev) >> 27);
		rot    = prev[63:59];
		return (xs >> rot) | (xs << (WORD_W - rot));
	endfunction

	function automatic void lcg_reseed();
		lcg_inc = {stream_reg, 1'b1};
		lcg_st  = '0;
		void'(lcg_advance());
		lcg_st = lcg_st + seed_reg;
		void'(lcg_advance());
	endfunction

	function automatic logic [WORD_W-1:0] below_bound(input logic [WORD_W-1:0] n);
		logic [2*WORD_W-1:0] p;
		logic [WORD_W-1:0]   thr;
		if (n == '0)
			return '0;
		p = {32'd0, lcg_advance()} * {32'd0, n};
		if (p[WORD_W-1:0] < n) begin
			thr = (~n + 1'b1) % n;
			while (p[WORD_W-1:0] < thr)
				p = {32'd0, lcg_advance()} * {32'd0, n};
		end
		return p[2*WORD_W-1:WORD_W];
	endfunction

	function automatic draw_result_t pcg_predict(input op_t op, input logic [WORD_W-1:0] bound,
			input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
		draw_result_t r;
		r = '0;
		case (op)
			OP_RESEED: begin
				lcg_reseed();
			end
			OP_RAW: begin
				r.word = lcg_advance();
				r.frac = r.word[WORD_W-1:8];
				r.coin = r.word[WORD_W-1];
			end
			OP_BOUNDED: begin
				r.word = below_bound(bound);
			end
			default: begin
				if ($signed(lo) >= $signed(hi))
					r.sres = lo;
				else
					r.sres = lo + below_bound(hi - lo + 1'b1);
			end
		endcase
		return r;
	endfunction

	function automatic void check_draw(input draw_result_t got);
		draw_result_t want;
		if (pending_draws.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: word %h sres %h frac %h coin %b",
					got.word, got.sres, got.frac, got.coin);
			return;
		end
		want = pending_draws.pop_front();
		if (got.word !== want.word || got.sres !== want.sres || got.frac !== want.frac
				|| got.coin !== want.coin) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result differs: word %h/%h sres %h/%h frac %h/%h coin %b/%b (exp/got)",
					want.word, got.word, want.sres, got.sres, want.frac, got.frac,
					want.coin, got.coin);
		end
	endfunction

	// result sink: random stalls per transfer, plus the long hold-off
	always @(posedge clk) begin
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			check_draw({res_ch.word, res_ch.signed_result, res_ch.unit_fraction, res_ch.coin});
			rx_wait = idle_on ? $urandom_range(0, 3) : 0;
		end else if (rx_wait > 0) begin
			rx_wait--;
		end
		res_ch.ready <= (rx_wait == 0) && (hold_left == 0);
	end

	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	task automatic send_cmd(input op_t op, input logic [WORD_W-1:0] bound,
			input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.operation  <= op;
		cmd_ch.bound      <= bound;
		cmd_ch.range_low  <= lo;
		cmd_ch.range_high <= hi;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		pending_draws.push_back(pcg_predict(op, bound, lo, hi));
	endtask

	task automatic send_random_cmd();
		int                pick;
		op_t               op;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
		pick = $urandom_range(0, 99);
		op = (pick < 5) ? OP_RESEED : (pick < 30) ? OP_RAW : (pick < 65) ? OP_BOUNDED : OP_INTERVAL;
		b  = $urandom;
		lo = $urandom;
		hi = $urandom;
		case ($urandom_range(0, 5))
			0: begin
				b  = $urandom_range(0, 16);
				hi = lo + $urandom_range(0, 16);
			end
			1: begin
				b  = 32'h8000_0000 + $urandom_range(0, 255);
				hi = lo + 32'h7FFF_FFFF + $urandom_range(0, 255);
			end
			2: begin
				b  = 32'hFFFF_FFFF - $urandom_range(0, 3);
				lo = 32'h8000_0000 + $urandom_range(0, 3);
				hi = 32'h7FFF_FFFF - $urandom_range(0, 3);
			end
			default: ;
		endcase
		send_cmd(op, b, lo, hi);
	endtask

	// drop valid and let the block go quiet
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (pending_draws.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_SEED)
			seed_reg = v;
		else
			stream_reg = v[STREAM_W-1:0];
	endtask

	task automatic directed_extremes();
		idle_on = 1'b1;
		send_cmd(OP_RAW, '1, '0, '0);
		send_cmd(OP_RAW, '0, '1, '1);
		send_cmd(OP_RESEED, '1, '1, '1);
		send_cmd(OP_RAW, '0, '0, '0);
		send_cmd(OP_BOUNDED, 32'd0, '1, '1);
		send_cmd(OP_BOUNDED, 32'd1, '0, '0);
		send_cmd(OP_BOUNDED, 32'd2, '0, '0);
		send_cmd(OP_BOUNDED, 32'd3, '0, '0);
		send_cmd(OP_BOUNDED, 32'h8000_0000, '0, '0);
		send_cmd(OP_BOUNDED, 32'h8000_0001, '0, '0);
		send_cmd(OP_BOUNDED, 32'hFFFF_FFFF, '0, '0);
		send_cmd(OP_BOUNDED, 32'hFFFF_FFFE, '0, '0);
		send_cmd(OP_INTERVAL, '0, 32'd5, 32'd5);
		send_cmd(OP_INTERVAL, '0, 32'd7, -32'sd3);
		send_cmd(OP_INTERVAL, '1, 32'h7FFF_FFFF, 32'h8000_0000);
		send_cmd(OP_INTERVAL, '0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_cmd(OP_INTERVAL, '0, 32'h8000_0000, 32'h8000_0001);
		send_cmd(OP_INTERVAL, '0, 32'h7FFF_FFFE, 32'h7FFF_FFFF);
		send_cmd(OP_INTERVAL, '0, -32'sd5, 32'd5);
		send_cmd(OP_INTERVAL, '0, 32'h8000_0000, 32'hFFFF_FFFF);
		send_cmd(OP_INTERVAL, '0, 32'hFFFF_FFFF, 32'h7FFF_FFFE);
		send_cmd(OP_INTERVAL, '0, 32'h8000_0001, 32'h7FFF_FFFF);
		send_cmd(OP_RESEED, '0, '0, '0);
		wait_idle();
	endtask

	task automatic output_backpressure();
		idle_on = 1'b1;
		hold_left <= 400;
		repeat (40) send_random_cmd();
		wait_idle();
	endtask

	task automatic config_sweep();
		logic [CFG_DATA_W-1:0] seeds[5];
		logic [CFG_DATA_W-1:0] streams[5];
		seeds   = '{64'd0, '1, 64'h8000_0000_0000_0000, {$urandom, $urandom}, 64'd1};
		streams = '{64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, {1'b0, 31'($urandom), 32'($urandom)},
			64'h5555_5555_5555_5555};
		idle_on = 1'b1;
		for (int i = 0; i < 5; i++) begin
			cfg_write(REG_SEED, seeds[i]);
			cfg_write(REG_STREAM, streams[i]);
			send_cmd(OP_RAW, '0, '0, '0);
			send_cmd(OP_RESEED, $urandom, $urandom, $urandom);
			repeat (3) send_cmd(OP_RAW, $urandom, $urandom, $urandom);
			repeat (2) send_cmd(OP_BOUNDED, $urandom, '0, '0);
			repeat (2) send_random_cmd();
			wait_idle();
		end
	endtask

	task automatic random_traffic();
		for (int phase = 0; phase < 4; phase++) begin
			idle_on = (phase != 2);
			repeat (250) send_random_cmd();
			wait_idle();
			cfg_write(REG_SEED, {$urandom, $urandom});
			cfg_write(REG_STREAM, {1'b0, 31'($urandom), 32'($urandom)});
		end
		idle_on = 1'b1;
		send_cmd(OP_RESEED, '0, '0, '0);
		repeat (10) send_random_cmd();
		wait_idle();
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_index         = REG_SEED;
		cfg_data          = '0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.operation  = OP_RAW;
		cmd_ch.bound      = '0;
		cmd_ch.range_low  = '0;
		cmd_ch.range_high = '0;
		res_ch.ready      = 1'b0;
		idle_on           = 1'b1;
		hold_left         = 0;
		rx_wait           = 0;
		mismatches        = 0;
		seed_reg          = '0;
		stream_reg        = '0;
		lcg_reseed();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		directed_extremes();
		output_backpressure();
		config_sweep();
		random_traffic();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("pcg32_bounded_random_generator_top: match");
		else
			$display("pcg32_bounded_random_generator_top: mismatch");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("pcg32_bounded_random_generator_top: mismatch");
		$finish;
	end

endmodule
